>>> sv/assert_macros.svh
// Assertion helpers: same-cycle and next-cycle implication on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

>>> sv/hmng_pkg.sv
package hmng_pkg;

  localparam int InDataW  = 48;
  localparam int OutDataW = 120;
  localparam int CfgIdxW  = 3;
  localparam int DvdW     = 48;

  typedef enum logic [2:0] {
    REG_COLUMNS    = 3'd0,
    REG_ROWS       = 3'd1,
    REG_X_INTERVAL = 3'd2,
    REG_Y_INTERVAL = 3'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    RD_MID = 3'd0,
    RD_LX  = 3'd1,
    RD_HX  = 3'd2,
    RD_LY  = 3'd3,
    RD_HY  = 3'd4
  } rd_sel_t;

  typedef enum logic [2:0] {
    DIV_GX = 3'd0,
    DIV_GY = 3'd1,
    DIV_NX = 3'd2,
    DIV_NY = 3'd3,
    DIV_NZ = 3'd4
  } div_op_t;

  typedef struct packed {
    logic    load_in;
    logic    mem_we;
    logic    mem_re;
    rd_sel_t rd_sel;
    logic    delta_go;
    logic    div_go;
    div_op_t div_op;
    logic    mul_go;
    logic    mul_sel;
    logic    acc_init;
    logic    acc_add;
    logic    sqrt_go;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic oob;
    logic func;
    logic div_busy;
    logic sqrt_busy;
  } sts_t;

endpackage

>>> sv/hmng_ctrl.sv
module hmng_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  hmng_pkg::sts_t  sts,
  output hmng_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_READ, S_RWAIT, S_DELTA, S_DIVGO, S_DIVW,
    S_SQX, S_SQY, S_SUM, S_SQGO, S_SQW, S_FINISH
  } state_t;

  state_t             state_r;
  hmng_pkg::rd_sel_t  rd_sel_r;
  hmng_pkg::div_op_t  div_op_r;
  logic               out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = rd_sel_r;
    cmd.div_op   = div_op_r;
    unique case (state_r)
      S_IDLE:   cmd.load_in  = in_valid;
      S_CHECK:  cmd.mem_we   = !sts.oob && !sts.func;
      S_READ:   cmd.mem_re   = 1'b1;
      S_RWAIT:  cmd.mem_re   = 1'b0;
      S_DELTA:  cmd.delta_go = 1'b1;
      S_DIVGO:  cmd.div_go   = 1'b1;
      S_DIVW:   cmd.div_go   = 1'b0;
      S_SQX:    cmd.mul_go   = 1'b1;
      S_SQY: begin
        cmd.mul_go   = 1'b1;
        cmd.mul_sel  = 1'b1;
        cmd.acc_init = 1'b1;
      end
      S_SUM:    cmd.acc_add  = 1'b1;
      S_SQGO:   cmd.sqrt_go  = 1'b1;
      S_SQW:    cmd.sqrt_go  = 1'b0;
      S_FINISH: cmd.load_out = !out_valid_r || out_ready;
      default:  cmd.load_in  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_sel_r    <= hmng_pkg::RD_MID;
      div_op_r    <= hmng_pkg::DIV_GX;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_FINISH && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            rd_sel_r <= hmng_pkg::RD_MID;
            state_r  <= S_CHECK;
          end
        end
        S_CHECK: begin
          rd_sel_r <= hmng_pkg::RD_MID;
          state_r  <= (sts.oob || !sts.func) ? S_FINISH : S_READ;
        end
        S_READ: begin
          unique case (rd_sel_r)
            hmng_pkg::RD_MID: rd_sel_r <= hmng_pkg::RD_LX;
            hmng_pkg::RD_LX:  rd_sel_r <= hmng_pkg::RD_HX;
            hmng_pkg::RD_HX:  rd_sel_r <= hmng_pkg::RD_LY;
            hmng_pkg::RD_LY:  rd_sel_r <= hmng_pkg::RD_HY;
            default:          state_r  <= S_RWAIT;
          endcase
        end
        S_RWAIT: state_r <= S_DELTA;
        S_DELTA: begin
          div_op_r <= hmng_pkg::DIV_GX;
          state_r  <= S_DIVGO;
        end
        S_DIVGO: state_r <= S_DIVW;
        S_DIVW: begin
          if (!sts.div_busy) begin
            unique case (div_op_r)
              hmng_pkg::DIV_GX: begin
                div_op_r <= hmng_pkg::DIV_GY;
                state_r  <= S_DIVGO;
              end
              hmng_pkg::DIV_GY: state_r <= S_SQX;
              hmng_pkg::DIV_NX: begin
                div_op_r <= hmng_pkg::DIV_NY;
                state_r  <= S_DIVGO;
              end
              hmng_pkg::DIV_NY: begin
                div_op_r <= hmng_pkg::DIV_NZ;
                state_r  <= S_DIVGO;
              end
              default: state_r <= S_FINISH;
            endcase
          end
        end
        S_SQX:  state_r <= S_SQY;
        S_SQY:  state_r <= S_SUM;
        S_SUM:  state_r <= S_SQGO;
        S_SQGO: state_r <= S_SQW;
        S_SQW: begin
          if (!sts.sqrt_busy) begin
            div_op_r <= hmng_pkg::DIV_NX;
            state_r  <= S_DIVGO;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/hmng_dp.sv
module hmng_dp #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [hmng_pkg::CfgIdxW-1:0]       cfg_idx,
  input  logic [31:0]                        cfg_wdata,
  input  logic                               in_func,
  input  logic [hmng_pkg::InDataW-1:0]       in_data,
  input  hmng_pkg::cmd_t                     cmd,
  output hmng_pkg::sts_t                     sts,
  output logic                               out_status,
  output logic [hmng_pkg::OutDataW-1:0]      out_data
);

  localparam int NCW   = $clog2(MAX_COLUMNS + 1);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int CW    = (NCW > 9) ? NCW : 9;
  localparam int RW    = (NRW > 9) ? NRW : 9;
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = hmng_pkg::DvdW;

  logic [8:0]  cols_r, rows_r;
  logic [31:0] xint_r, yint_r;

  logic        func_r;
  logic [7:0]  col_r, row_r;
  logic [31:0] hval_r;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_r;
  logic        cap_v_r;
  hmng_pkg::rd_sel_t cap_sel_r;
  logic signed [31:0] h_mid_r, h_lx_r, h_hx_r, h_ly_r, h_hy_r;

  logic signed [32:0] dx_r, dy_r;
  logic [31:0] gx_mag_r, gy_mag_r;
  logic        gx_neg_r, gy_neg_r;
  logic [63:0] mul_r, acc_r;
  logic [31:0] len_r;
  logic [15:0] nx_r, ny_r;
  logic [14:0] nz_r;

  logic [DW-1:0] dv_q_r;
  logic [31:0]   dv_rem_r, dv_den_r;
  logic [5:0]    dv_cnt_r;
  logic          dv_busy_r;
  hmng_pkg::div_op_t dv_op_r;

  logic [63:0] sq_rem_r, sq_res_r;
  logic [4:0]  sq_k_r;
  logic        sq_busy_r;

  logic        st_r;
  logic [hmng_pkg::OutDataW-1:0] od_r;

  logic [CW-1:0] nc, col_e;
  logic [RW-1:0] nr, row_e;
  logic [7:0]    col_a, row_a;
  logic [AW-1:0] addr;
  logic          oob;

  always_comb begin
    if (cols_r < 9'd2)                    nc = CW'(2);
    else if (CW'(cols_r) > CW'(MAX_COLUMNS)) nc = CW'(MAX_COLUMNS);
    else                                  nc = CW'(cols_r);
    if (rows_r < 9'd2)                    nr = RW'(2);
    else if (RW'(rows_r) > RW'(MAX_ROWS)) nr = RW'(MAX_ROWS);
    else                                  nr = RW'(rows_r);
  end

  assign col_e = CW'(col_r);
  assign row_e = RW'(row_r);
  assign oob   = (col_e >= nc) || (row_e >= nr);
  assign sts.oob       = oob;
  assign sts.func      = func_r;
  assign sts.div_busy  = dv_busy_r;
  assign sts.sqrt_busy = sq_busy_r;

  always_comb begin
    col_a = col_r;
    row_a = row_r;
    case (cmd.rd_sel)
      hmng_pkg::RD_LX: if (col_r != 8'd0) col_a = col_r - 8'd1;
      hmng_pkg::RD_HX: if (col_e + CW'(1) < nc) col_a = col_r + 8'd1;
      hmng_pkg::RD_LY: if (row_r != 8'd0) row_a = row_r - 8'd1;
      hmng_pkg::RD_HY: if (row_e + RW'(1) < nr) row_a = row_r + 8'd1;
      default: col_a = col_r;
    endcase
  end

  assign addr = AW'(row_a) * AW'(MAX_COLUMNS) + AW'(col_a);

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[addr] <= hval_r;
    rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= 9'd256;
      rows_r  <= 9'd256;
      xint_r  <= 32'd65536;
      yint_r  <= 32'd65536;
      cap_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          hmng_pkg::REG_COLUMNS:    cols_r <= cfg_wdata[8:0];
          hmng_pkg::REG_ROWS:       rows_r <= cfg_wdata[8:0];
          hmng_pkg::REG_X_INTERVAL: xint_r <= cfg_wdata;
          hmng_pkg::REG_Y_INTERVAL: yint_r <= cfg_wdata;
          default:                  cols_r <= cols_r;
        endcase
      end
      cap_v_r <= cmd.mem_re;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      col_r  <= in_data[7:0];
      row_r  <= in_data[15:8];
      hval_r <= in_data[47:16];
    end
    cap_sel_r <= cmd.rd_sel;
    if (cap_v_r) begin
      case (cap_sel_r)
        hmng_pkg::RD_MID: h_mid_r <= rd_r;
        hmng_pkg::RD_LX:  h_lx_r  <= rd_r;
        hmng_pkg::RD_HX:  h_hx_r  <= rd_r;
        hmng_pkg::RD_LY:  h_ly_r  <= rd_r;
        default:          h_hy_r  <= rd_r;
      endcase
    end
  end

  logic signed [32:0] mid_e, lx_e, hx_e, ly_e, hy_e, dfx, dfy, dx_c, dy_c;

  always_comb begin
    mid_e = {h_mid_r[31], h_mid_r};
    lx_e  = {h_lx_r[31], h_lx_r};
    hx_e  = {h_hx_r[31], h_hx_r};
    ly_e  = {h_ly_r[31], h_ly_r};
    hy_e  = {h_hy_r[31], h_hy_r};
    dfx   = hx_e - lx_e;
    dfy   = hy_e - ly_e;
    if (col_r == 8'd0)                dx_c = hx_e - mid_e;
    else if (col_e == nc - CW'(1))    dx_c = mid_e - lx_e;
    else                              dx_c = dfx >>> 1;
    if (row_r == 8'd0)                dy_c = hy_e - mid_e;
    else if (row_e == nr - RW'(1))    dy_c = mid_e - ly_e;
    else                              dy_c = dfy >>> 1;
  end

  always_ff @(posedge clk) begin
    if (cmd.delta_go) begin
      dx_r <= dx_c;
      dy_r <= dy_c;
    end
  end

  logic [32:0]   ndx, ndy;
  logic [31:0]   dxm, dym, xe, ye;
  logic [DW-1:0] dv_dvd;
  logic [31:0]   dv_den;
  logic [DW-1:0] half_len;

  assign ndx      = -dx_r;
  assign ndy      = -dy_r;
  assign dxm      = dx_r[32] ? ndx[31:0] : dx_r[31:0];
  assign dym      = dy_r[32] ? ndy[31:0] : dy_r[31:0];
  assign xe       = (xint_r == 32'd0) ? 32'd1 : xint_r;
  assign ye       = (yint_r == 32'd0) ? 32'd1 : yint_r;
  assign half_len = DW'(len_r >> 1);

  always_comb begin
    case (cmd.div_op)
      hmng_pkg::DIV_GX: begin dv_dvd = {dxm, 16'd0}; dv_den = xe; end
      hmng_pkg::DIV_GY: begin dv_dvd = {dym, 16'd0}; dv_den = ye; end
      hmng_pkg::DIV_NX: begin dv_dvd = DW'({gx_mag_r, 14'd0}) + half_len; dv_den = len_r; end
      hmng_pkg::DIV_NY: begin dv_dvd = DW'({gy_mag_r, 14'd0}) + half_len; dv_den = len_r; end
      default: begin dv_dvd = DW'(64'd1 << 30) + half_len; dv_den = len_r; end
    endcase
  end

  logic [32:0]   dv_t;
  logic          dv_ge;
  logic [32:0]   dv_sub;
  logic [31:0]   dv_rem_nxt;
  logic [DW-1:0] dv_q_nxt;
  logic [31:0]   sat_x, sat_y;

  always_comb begin
    dv_t       = {dv_rem_r, dv_q_r[DW-1]};
    dv_ge      = dv_t >= {1'b0, dv_den_r};
    dv_sub     = dv_t - {1'b0, dv_den_r};
    dv_rem_nxt = dv_ge ? dv_sub[31:0] : dv_t[31:0];
    dv_q_nxt   = {dv_q_r[DW-2:0], dv_ge};
    sat_x      = dx_r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat_y      = dy_r[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (cmd.div_go) begin
      dv_busy_r <= 1'b1;
    end else if (dv_busy_r && dv_cnt_r == 6'd1) begin
      dv_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      dv_q_r   <= dv_dvd;
      dv_rem_r <= 32'd0;
      dv_den_r <= dv_den;
      dv_cnt_r <= 6'(DW);
      dv_op_r  <= cmd.div_op;
    end else if (dv_busy_r) begin
      dv_q_r   <= dv_q_nxt;
      dv_rem_r <= dv_rem_nxt;
      dv_cnt_r <= dv_cnt_r - 6'd1;
      if (dv_cnt_r == 6'd1) begin
        case (dv_op_r)
          hmng_pkg::DIV_GX: begin
            gx_mag_r <= (dv_q_nxt > DW'(sat_x)) ? sat_x : dv_q_nxt[31:0];
            gx_neg_r <= dx_r[32];
          end
          hmng_pkg::DIV_GY: begin
            gy_mag_r <= (dv_q_nxt > DW'(sat_y)) ? sat_y : dv_q_nxt[31:0];
            gy_neg_r <= dy_r[32];
          end
          hmng_pkg::DIV_NX:
            nx_r <= gx_neg_r ? {1'b0, dv_q_nxt[14:0]} : -{1'b0, dv_q_nxt[14:0]};
          hmng_pkg::DIV_NY:
            ny_r <= gy_neg_r ? {1'b0, dv_q_nxt[14:0]} : -{1'b0, dv_q_nxt[14:0]};
          default: nz_r <= dv_q_nxt[14:0];
        endcase
      end
    end
  end

  logic [31:0] mop;
  logic [63:0] prod;

  assign mop  = cmd.mul_sel ? gy_mag_r : gx_mag_r;
  assign prod = mop * mop;

  always_ff @(posedge clk) begin
    if (cmd.mul_go)   mul_r <= prod;
    if (cmd.acc_init) acc_r <= mul_r + (64'd1 << 32);
    else if (cmd.acc_add) acc_r <= acc_r + mul_r;
  end

  logic [63:0] sq_bit, sq_trial;
  assign sq_bit   = 64'd1 << {sq_k_r, 1'b0};
  assign sq_trial = sq_res_r + sq_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.sqrt_go) begin
      sq_busy_r <= 1'b1;
    end else if (sq_busy_r && sq_k_r == 5'd0) begin
      sq_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_go) begin
      sq_rem_r <= acc_r;
      sq_res_r <= 64'd0;
      sq_k_r   <= 5'd31;
    end else if (sq_busy_r) begin
      if (sq_rem_r >= sq_trial) begin
        sq_rem_r <= sq_rem_r - sq_trial;
        sq_res_r <= (sq_res_r >> 1) + sq_bit;
        if (sq_k_r == 5'd0) len_r <= sq_res_r[32:1] + sq_bit[31:0];
      end else begin
        sq_res_r <= sq_res_r >> 1;
        if (sq_k_r == 5'd0) len_r <= sq_res_r[32:1];
      end
      sq_k_r <= sq_k_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      st_r <= oob;
      if (!oob && func_r) begin
        od_r <= {7'd0, nz_r, ny_r, nx_r, dy_r, dx_r};
      end else begin
        od_r <= '0;
      end
    end
  end

  assign out_status = st_r;
  assign out_data   = od_r;

endmodule

>>> sv/heightmap_normal_and_gradient.sv
// A store or out-of-grid item goes right to its result; a query reads five heights,
// then two serial divisions, a bit-serial square root and three more divisions.
// Flow: one item at a time; one bit-serial divider is shared by all five divisions.
// Reset (rst_n low, synchronous): controller idle, no result pending, registers at
// 256 columns, 256 rows and unit intervals; the height memory is not cleared.
`include "assert_macros.svh"

module heightmap_normal_and_gradient #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // column[7:0], row[15:8], height_value[47:16]
  input  logic [hmng_pkg::InDataW-1:0]       in_tdata,
  // func[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // delta_x[32:0], delta_y[65:33], normal_x[81:66], normal_y[97:82],
  // normal_z[112:98], zero[119:113]
  output logic [hmng_pkg::OutDataW-1:0]      out_tdata,
  // status[0]
  output logic                               out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hmng_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [31:0]                        cfg_data
);

  hmng_pkg::cmd_t cmd;
  hmng_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  hmng_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hmng_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .in_func    (in_tuser),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_tuser),
    .out_data   (out_tdata)
  );

  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `ASSERT_NOW(a_oob_zero, out_tvalid && out_tuser, out_tdata == '0, "error beat not zero")

endmodule
